// File: rtl/core/nbt_pkg.sv
`timescale 1ns / 1ps

package nbt_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [2:0] {
        FN_UPD_BACKLOG = 3'd0,
        FN_UPD_HOPS    = 3'd1,
        FN_TICK        = 3'd2,
        FN_FIND        = 3'd3,
        FN_CLEAR       = 3'd4,
        FN_DROP        = 3'd5
    } t_func;

    localparam int FUNC_W    = 3;
    localparam int VAL_W     = 16;
    localparam int HOLD_W    = 4;
    localparam int CNT_OUT_W = 5;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [HOLD_W-1:0] HOLDOFF_ARM = 4'd11;
    localparam logic [HOLD_W-1:0] HOLDOFF_ONE = 4'd1;
    localparam logic [VAL_W-1:0]  NO_HOPS     = 16'hffff;
    localparam logic [VAL_W-1:0]  LIMIT_RESET = 16'd32;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic proc;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// File: rtl/core/nbt_ram.sv
`timescale 1ns / 1ps

module nbt_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/nbt_ctrl.sv
`timescale 1ns / 1ps

module nbt_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [$clog2(ENTRIES+1)-1:0]   i_count,
    input  nbt_pkg::t_dp_status            i_status,
    output nbt_pkg::t_dp_cmd               o_cmd,
    output logic [$clog2(ENTRIES)-1:0]     o_rd_ptr,
    output logic [$clog2(ENTRIES)-1:0]     o_proc_ptr
);

    localparam int IW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [PW-1:0]   r_ptr;
    logic            r_proc;
    logic [IW-1:0]   r_proc_ptr;
    logic            w_rd_issue;

    assign w_rd_issue = (r_state == S_SCAN) && (r_ptr < i_count);

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en  = w_rd_issue;
        o_cmd.proc   = r_proc;
        o_cmd.finish = (r_state == S_DONE) && !i_status.out_busy;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_rd_ptr   = r_ptr[IW-1:0];
    assign o_proc_ptr = r_proc_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ptr      <= '0;
            r_proc     <= 1'b0;
            r_proc_ptr <= '0;
        end else begin
            // read data comes back in the cycle after the address
            r_proc <= w_rd_issue;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ptr   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_rd_issue) begin
                        r_proc_ptr <= r_ptr[IW-1:0];
                        r_ptr      <= r_ptr + PW'(1);
                    end else begin
                        // last entry is being processed this cycle
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/nbt_datapath.sv
`timescale 1ns / 1ps

module nbt_datapath #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nbt_pkg::t_dp_cmd                     i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]           i_rd_ptr,
    input  logic [$clog2(ENTRIES)-1:0]           i_proc_ptr,
    input  logic [nbt_pkg::FUNC_W-1:0]           i_func,
    input  logic [nbt_pkg::VAL_W-1:0]            i_neighbor,
    input  logic [nbt_pkg::VAL_W-1:0]            i_queue_value,
    input  logic                                 i_is_data,
    input  logic [nbt_pkg::VAL_W-1:0]            i_hop_value,
    input  logic                                 i_cfg_we,
    input  logic [nbt_pkg::VAL_W-1:0]            i_cfg_wdata,
    input  logic                                 i_out_ready,
    output logic [$clog2(ENTRIES+1)-1:0]         o_count,
    output nbt_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    output logic                                 o_ok,
    output logic                                 o_found,
    output logic [nbt_pkg::VAL_W-1:0]            o_best_neighbor,
    output logic [nbt_pkg::VAL_W-1:0]            o_best_hops,
    output logic [nbt_pkg::CNT_OUT_W-1:0]        o_entry_count
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int PW    = $clog2(ENTRIES + 1);
    localparam int VW    = nbt_pkg::VAL_W;
    localparam int HW    = nbt_pkg::HOLD_W;
    localparam int REC_W = ADDR_BITS + 2 * VW + HW;

    // item registers
    logic [nbt_pkg::FUNC_W-1:0] r_func;
    logic [ADDR_BITS-1:0]       r_addr;
    logic [VW-1:0]              r_qv;
    logic                       r_is_data;
    logic [VW-1:0]              r_hv;

    logic [VW-1:0]              r_limit;
    logic [PW-1:0]              r_count;
    logic [PW-1:0]              r_wr_ptr;
    logic                       r_match;
    logic                       r_found;
    logic [VW-1:0]              r_best_hops;
    logic [ADDR_BITS-1:0]       r_best_addr;

    logic                       r_out_valid;
    logic                       r_out_ok;
    logic                       r_out_found;
    logic [VW-1:0]              r_out_best_addr;
    logic [VW-1:0]              r_out_best_hops;
    logic [nbt_pkg::CNT_OUT_W-1:0] r_out_count;

    logic [REC_W-1:0]           w_rd_data;
    logic [ADDR_BITS-1:0]       w_rec_addr;
    logic [VW-1:0]              w_rec_backlog;
    logic [HW-1:0]              w_rec_hold;
    logic [VW-1:0]              w_rec_hops;

    logic                       w_is_upd;
    logic                       w_addr_hit;
    logic                       w_keep;
    logic                       w_better;
    logic                       w_full;
    logic [VW-1:0]              w_clamped;
    logic [HW-1:0]              w_tick_hold;
    logic [VW-1:0]              w_base_backlog;
    logic [HW-1:0]              w_base_hold;
    logic [VW-1:0]              w_base_hops;
    logic [VW-1:0]              w_upd_backlog;
    logic [HW-1:0]              w_upd_hold;
    logic [VW-1:0]              w_upd_hops;
    logic [PW-1:0]              w_count_next;
    logic                       w_ok;

    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    logic [REC_W-1:0]           w_wdata;

    nbt_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_ptr),
        .o_rdata (w_rd_data)
    );

    assign {w_rec_addr, w_rec_backlog, w_rec_hold, w_rec_hops} = w_rd_data;

    assign w_is_upd   = (r_func == nbt_pkg::FN_UPD_BACKLOG) || (r_func == nbt_pkg::FN_UPD_HOPS);
    assign w_addr_hit = (w_rec_addr == r_addr);
    assign w_keep     = (w_rec_hold != nbt_pkg::HOLDOFF_ONE);
    assign w_better   = (w_rec_hops != '0) && (w_rec_hops <= r_best_hops);
    assign w_full     = (r_count >= PW'(ENTRIES));
    assign w_clamped  = (r_qv > r_limit) ? r_limit : r_qv;

    // hold-off of zero or one settles at one, anything else counts down
    assign w_tick_hold = (w_rec_hold <= nbt_pkg::HOLDOFF_ONE) ? nbt_pkg::HOLDOFF_ONE
                                                             : w_rec_hold - HW'(1);

    // new entry starts from zeros, a hit starts from the stored fields
    assign w_base_backlog = i_cmd.finish ? '0 : w_rec_backlog;
    assign w_base_hold    = i_cmd.finish ? '0 : w_rec_hold;
    assign w_base_hops    = i_cmd.finish ? '0 : w_rec_hops;

    assign w_upd_backlog = (r_func == nbt_pkg::FN_UPD_BACKLOG) ? w_clamped : w_base_backlog;
    assign w_upd_hold    = ((r_func == nbt_pkg::FN_UPD_BACKLOG) && r_is_data)
                           ? nbt_pkg::HOLDOFF_ARM : w_base_hold;
    assign w_upd_hops    = (r_func == nbt_pkg::FN_UPD_HOPS) ? r_hv : w_base_hops;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_proc_ptr;
        w_wdata = {r_addr, w_upd_backlog, w_upd_hold, w_upd_hops};
        if (i_cmd.proc) begin
            case (r_func)
                nbt_pkg::FN_UPD_BACKLOG,
                nbt_pkg::FN_UPD_HOPS: begin
                    w_we = w_addr_hit;
                end
                nbt_pkg::FN_TICK: begin
                    w_we    = 1'b1;
                    w_wdata = {w_rec_addr, w_rec_backlog, w_tick_hold, w_rec_hops};
                end
                nbt_pkg::FN_DROP: begin
                    // compact survivors towards the head, order kept
                    w_we    = w_keep;
                    w_waddr = r_wr_ptr[IW-1:0];
                    w_wdata = w_rd_data;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end else if (i_cmd.finish) begin
            // append a missing neighbour at the tail
            w_we    = w_is_upd && !r_match && !w_full;
            w_waddr = r_count[IW-1:0];
        end
    end

    always_comb begin
        w_ok = 1'b1;
        case (r_func)
            nbt_pkg::FN_UPD_BACKLOG,
            nbt_pkg::FN_UPD_HOPS: begin
                if (r_match) begin
                    w_count_next = r_count;
                end else if (w_full) begin
                    w_count_next = r_count;
                    w_ok         = 1'b0;
                end else begin
                    w_count_next = r_count + PW'(1);
                end
            end
            nbt_pkg::FN_CLEAR: begin
                w_count_next = '0;
            end
            nbt_pkg::FN_DROP: begin
                w_count_next = r_wr_ptr;
            end
            default: begin
                w_count_next = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= nbt_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_count     <= w_count_next;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_addr      <= ADDR_BITS'(i_neighbor);
            r_qv        <= i_queue_value;
            r_is_data   <= i_is_data;
            r_hv        <= i_hop_value;
            r_match     <= 1'b0;
            r_found     <= 1'b0;
            r_best_hops <= nbt_pkg::NO_HOPS;
            r_wr_ptr    <= '0;
        end
        if (i_cmd.proc) begin
            case (r_func)
                nbt_pkg::FN_UPD_BACKLOG,
                nbt_pkg::FN_UPD_HOPS: begin
                    if (w_addr_hit) begin
                        r_match <= 1'b1;
                    end
                end
                nbt_pkg::FN_FIND: begin
                    // scan runs oldest first, so a tie goes to the later entry
                    if (w_better) begin
                        r_found     <= 1'b1;
                        r_best_hops <= w_rec_hops;
                        r_best_addr <= w_rec_addr;
                    end
                end
                nbt_pkg::FN_DROP: begin
                    if (w_keep) begin
                        r_wr_ptr <= r_wr_ptr + PW'(1);
                    end
                end
                default: begin
                    r_match <= r_match;
                end
            endcase
        end
        if (i_cmd.finish) begin
            r_out_ok        <= w_ok;
            r_out_found     <= r_found;
            r_out_best_addr <= r_found ? VW'(r_best_addr) : '0;
            r_out_best_hops <= r_found ? r_best_hops : '0;
            r_out_count     <= nbt_pkg::CNT_OUT_W'(w_count_next);
        end
    end

    assign o_count           = r_count;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_out_ok;
    assign o_found           = r_out_found;
    assign o_best_neighbor   = r_out_best_addr;
    assign o_best_hops       = r_out_best_hops;
    assign o_entry_count     = r_out_count;

endmodule

// File: rtl/core/neighbor_backpressure_table.sv
`timescale 1ns / 1ps

// Channel    Dir   Handshake                      Payload
// s_axis     in    s_axis_tvalid / s_axis_tready   tdata 48b, tuser 4b (one operation)
// m_axis     out   m_axis_tvalid / m_axis_tready   tdata 40b, tuser 2b (one result)
// cfg        in    i_cfg_we                        i_cfg_wdata 16b (queue limit)
//
// An item is taken in, then each entry held before it is read in turn through the
// single read port of the entry RAM, whose read is registered, and finally its result
// is posted. Entries sit packed in insertion order.
// Reset empties the table at once by clearing the fill count; no clearing pass.
// A result left waiting at m_axis stalls the next item only at its final cycle.

module neighbor_backpressure_table #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // neighbor[15:0], queue_value[31:16], hop_value[47:32]
    input  logic [nbt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func[2:0], is_data[3]
    input  logic [nbt_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // best_neighbor[15:0], best_hops[31:16], entry_count[36:32], zero[39:37]
    output logic [nbt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // ok[0], found[1]
    output logic [nbt_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [nbt_pkg::VAL_W-1:0]         i_cfg_wdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);

    nbt_pkg::t_dp_cmd             w_cmd;
    nbt_pkg::t_dp_status          w_status;
    logic [IW-1:0]                w_rd_ptr;
    logic [IW-1:0]                w_proc_ptr;
    logic [PW-1:0]                w_count;
    logic                         w_ok;
    logic                         w_found;
    logic [nbt_pkg::VAL_W-1:0]    w_best_neighbor;
    logic [nbt_pkg::VAL_W-1:0]    w_best_hops;
    logic [nbt_pkg::CNT_OUT_W-1:0] w_entry_count;

    nbt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_count    (w_count),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_rd_ptr   (w_rd_ptr),
        .o_proc_ptr (w_proc_ptr)
    );

    nbt_datapath #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_ptr        (w_rd_ptr),
        .i_proc_ptr      (w_proc_ptr),
        .i_func          (s_axis_tuser[2:0]),
        .i_neighbor      (s_axis_tdata[15:0]),
        .i_queue_value   (s_axis_tdata[31:16]),
        .i_is_data       (s_axis_tuser[3]),
        .i_hop_value     (s_axis_tdata[47:32]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (m_axis_tready),
        .o_count         (w_count),
        .o_status        (w_status),
        .o_out_valid     (m_axis_tvalid),
        .o_ok            (w_ok),
        .o_found         (w_found),
        .o_best_neighbor (w_best_neighbor),
        .o_best_hops     (w_best_hops),
        .o_entry_count   (w_entry_count)
    );

    assign m_axis_tdata = {3'b000, w_entry_count, w_best_hops, w_best_neighbor};
    assign m_axis_tuser = {w_found, w_ok};

endmodule

// File: rtl/core/nbt_checker.sv
`timescale 1ns / 1ps

module nbt_checker #(
    parameter int ENTRIES = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [nbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [nbt_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam bit CNT_FITS = (ENTRIES < 32);

    // a stalled result stays up
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && CNT_FITS |-> m_axis_tdata[36:32] <= 5'(ENTRIES))
        else $error("entry count above table size");

    // no match means all search fields read zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("search fields set without a match");

    // a failed insert only happens on a full table
    a_fail_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[36:32] == 5'(ENTRIES))
        else $error("insert refused with room left");

endmodule

bind neighbor_backpressure_table nbt_checker #(
    .ENTRIES (ENTRIES)
) u_nbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
